FILE: hdl/blz_pkg.sv
// Shared constants for the backward LZ decompressor: window geometry,
// parse phase and sequencer state codes and configuration register map. No dependencies.
package blz_pkg;

    localparam int WINDOW_BYTES = 8192;
    localparam int WIN_AW       = $clog2(WINDOW_BYTES);

    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;
    localparam int LEN_W    = 5;

    // Register indexes (word address, byte offset ignored).
    localparam logic CFG_OUTPUT_LENGTH = 1'b0;

    // Parse phase of the compressed stream.
    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_ITEM = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    // Sequencer states of the copy engine.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_WR   = 2'd2;

    localparam logic [3:0] MIN_MATCH  = 4'd3;
    localparam logic [3:0] FLAG_COUNT = 4'd8;

endpackage

FILE: hdl/backward_lz_decompressor_top.sv
// Top level of the backward LZ decompressor: parser, copy sequencer,
// history window and APB register. Depends on blz_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------
//  input   | in        | in_valid / in_ready  | comp_byte[7:0]
//  output  | out       | out_valid / out_ready| out_byte[7:0], out_last
//  config  | in / out  | APB psel / penable   | paddr[2:0], pwdata, prdata
//
// A flag byte, a pair high byte, or a literal is handled as it is accepted.
// A pair low byte starts a copy of up to 18 bytes through the single window
// memory port: per copied byte the sequencer reads the source byte, then
// writes it back and loads the output. No input is taken while a copy runs.
// Reset clears all control state; the window needs no clearing pass, since a
// fill mark (write pointer plus a wrapped flag) makes unwritten entries read
// as zero. A stalled output register holds the copy sequencer in place; a
// literal is refused while the output register is full and not taken.
module backward_lz_decompressor_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  comp_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_byte,
    output logic                        out_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [blz_pkg::CFG_AW-1:0]  paddr,
    input  logic [blz_pkg::CFG_DW-1:0]  pwdata,
    output logic [blz_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);
    import blz_pkg::*;

    localparam logic [WIN_AW-1:0] WIN_LAST = WIN_AW'(WINDOW_BYTES - 1);

    logic [CFG_DW-1:0] out_len_reg;
    logic [31:0]       remaining_reg, remaining_next;
    logic [1:0]        phase_reg, phase_next;
    logic [7:0]        flag_reg, flag_next;
    logic [3:0]        bits_left_reg, bits_left_next;
    logic [7:0]        pair_high_reg, pair_high_next;
    logic [WIN_AW-1:0] wp_reg, wp_next;
    logic              wrapped_reg, wrapped_next;
    logic [1:0]        state_reg, state_next;
    logic [WIN_AW-1:0] src_reg, src_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic              rd_hit_reg, rd_hit_next;
    logic [7:0]        rd_data_reg;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    logic [7:0] window_mem [WINDOW_BYTES];

    logic              cfg_we;
    logic              in_fire;
    logic              active;
    logic              lit_next;
    logic              lit_go;
    logic              cp_go;
    logic              emit;
    logic [7:0]        emit_byte;
    logic              mem_re;
    logic              pair_go;
    logic [WIN_AW-1:0] match_dist;
    logic [WIN_AW:0]   src_wrap;
    logic [WIN_AW-1:0] src_start;
    logic [LEN_W-1:0]  len_raw;
    logic [LEN_W-1:0]  len_clamped;
    logic [3:0]        bits_dec;

    assign pready = 1'b1;
    assign prdata = out_len_reg;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == CFG_OUTPUT_LENGTH);

    // The next input byte would be a literal, so it needs the output slot.
    assign active   = (remaining_reg != 32'd0);
    assign lit_next = active && (phase_reg == PH_ITEM) && !flag_reg[7];
    assign in_ready = (state_reg == ST_IDLE) && !(lit_next && out_valid_reg && !out_ready);
    assign in_fire  = in_valid && in_ready;

    assign lit_go  = in_fire && lit_next;
    assign pair_go = in_fire && active && (phase_reg == PH_LOW);
    assign cp_go   = (state_reg == ST_WR) && (!out_valid_reg || out_ready);
    assign emit    = lit_go || cp_go;
    assign emit_byte = lit_go ? comp_byte : (rd_hit_reg ? rd_data_reg : 8'h00);
    assign mem_re  = (state_reg == ST_RD);

    // Pair decode: distance and length from the 16-bit pair value.
    assign match_dist = WIN_AW'({pair_high_reg[3:0], comp_byte}) + WIN_AW'(MIN_MATCH);
    assign src_wrap = {1'b0, wp_reg} + (WIN_AW + 1)'(WINDOW_BYTES) - {1'b0, match_dist};
    assign src_start = (wp_reg >= match_dist) ? (wp_reg - match_dist) : src_wrap[WIN_AW-1:0];
    assign len_raw = LEN_W'(pair_high_reg[7:4]) + LEN_W'(MIN_MATCH);
    assign len_clamped = (remaining_reg < 32'(len_raw)) ? remaining_reg[LEN_W-1:0] : len_raw;
    assign bits_dec = (bits_left_reg != 4'd0) ? (bits_left_reg - 4'd1) : 4'd0;

    always_comb
    begin
        remaining_next = remaining_reg;
        phase_next     = phase_reg;
        flag_next      = flag_reg;
        bits_left_next = bits_left_reg;
        pair_high_next = pair_high_reg;
        wp_next        = wp_reg;
        wrapped_next   = wrapped_reg;
        state_next     = state_reg;
        src_next       = src_reg;
        count_next     = count_reg;
        rd_hit_next    = rd_hit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        // Parser: one step per accepted transaction while the stream is live.
        if (in_fire && active)
        begin
            unique case (phase_reg)
                PH_FLAG:
                begin
                    flag_next      = comp_byte;
                    bits_left_next = FLAG_COUNT;
                    phase_next     = PH_ITEM;
                end
                PH_ITEM:
                begin
                    if (flag_reg[7])
                    begin
                        pair_high_next = comp_byte;
                        phase_next     = PH_LOW;
                    end
                    else
                    begin
                        flag_next      = {flag_reg[6:0], 1'b0};
                        bits_left_next = bits_dec;
                        phase_next     = (bits_dec == 4'd0) ? PH_FLAG : PH_ITEM;
                    end
                end
                PH_LOW:
                begin
                    flag_next      = {flag_reg[6:0], 1'b0};
                    bits_left_next = bits_dec;
                    phase_next     = (bits_dec == 4'd0) ? PH_FLAG : PH_ITEM;
                end
                default:
                begin
                    phase_next = PH_FLAG;
                end
            endcase
        end

        // Copy sequencer: read the source byte, then write it back and emit it.
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pair_go)
                begin
                    src_next   = src_start;
                    count_next = len_clamped;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                rd_hit_next = wrapped_reg || (src_reg < wp_reg);
                src_next    = (src_reg == WIN_LAST) ? '0 : (src_reg + WIN_AW'(1));
                state_next  = ST_WR;
            end
            ST_WR:
            begin
                if (cp_go)
                begin
                    count_next = count_reg - LEN_W'(1);
                    state_next = (count_reg == LEN_W'(1)) ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_last_next  = (remaining_reg == 32'd1);
            remaining_next = remaining_reg - 32'd1;
            wp_next        = (wp_reg == WIN_LAST) ? '0 : (wp_reg + WIN_AW'(1));
            if (wp_reg == WIN_LAST)
            begin
                wrapped_next = 1'b1;
            end
        end

        // A new stream restarts parsing; the window and its pointer are kept.
        if (cfg_we)
        begin
            remaining_next = pwdata;
            phase_next     = PH_FLAG;
            bits_left_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_len_reg   <= '0;
            remaining_reg <= '0;
            phase_reg     <= PH_FLAG;
            flag_reg      <= '0;
            bits_left_reg <= '0;
            pair_high_reg <= '0;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_hit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                out_len_reg <= pwdata;
            end
            remaining_reg <= remaining_next;
            phase_reg     <= phase_next;
            flag_reg      <= flag_next;
            bits_left_reg <= bits_left_next;
            pair_high_reg <= pair_high_next;
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_hit_reg    <= rd_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    // History window: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            window_mem[wp_reg] <= emit_byte;
        end
        if (mem_re)
        begin
            rd_data_reg <= window_mem[src_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("input accepted while a copy is running");

    a_copy_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (count_reg != '0))
        else $error("copy sequencer active with zero bytes left");

    a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |=> (state_reg == ST_WR))
        else $error("window read not followed by write-back");

    a_last_ends_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && remaining_reg == 32'd1) |=> (remaining_reg == 32'd0 || $past(cfg_we)))
        else $error("final byte did not end the stream");
`endif

endmodule

FILE: tb/sv/backward_lz_decompressor_top_tb.sv
// Self-checking testbench for the backward LZ decompressor top level.
// Drives compressed bytes, register writes and output back-pressure, and
// checks each decompressed byte against an in-bench decoder. Needs blz_pkg.
module backward_lz_decompressor_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import blz_pkg::*;

    // Register map, byte addresses on the APB port.
    localparam logic [CFG_AW-1:0] ADDR_OUTPUT_LENGTH = {CFG_OUTPUT_LENGTH, 2'b00};
    localparam logic [CFG_AW-1:0] ADDR_UNMAPPED      = 3'd4;

    // Quiet cycles after the last predicted byte, enough for a pair low byte
    // copying 18 bytes to settle.
    localparam int DRAIN_CYCLES = 48;
    // Longest run of cycles with no transaction anywhere before giving up.
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 75;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [7:0]          comp_byte;
    logic                out_valid;
    logic                out_ready;
    logic [7:0]          out_byte;
    logic                out_last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [CFG_DW-1:0]   pwdata;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    // Decoder state mirrored from the block, plus the configured length.
    logic [31:0]         dec_length;
    logic [1:0]          dec_phase;
    logic [7:0]          dec_flags;
    logic [3:0]          dec_bits_left;
    logic [7:0]          dec_pair_high;
    logic [31:0]         dec_remaining;
    int                  dec_wr_ptr;
    logic [7:0]          dec_window [WINDOW_BYTES];

    out_beat_t           expected_beats[$];
    out_beat_t           want_beat;
    int                  mismatch_count = 0;
    int                  quiet_cycles   = 0;

    // Knobs set by the stimulus for the send task and the output-side ready process.
    int                  rx_hold   = 0;
    bit                  rx_steady = 1'b0;
    bit                  tx_steady = 1'b0;

    backward_lz_decompressor_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .comp_byte (comp_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Free-running clock, 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder used for prediction. Every accepted input transaction goes
    // through decode_comp_byte, which appends the bytes it produces to
    // expected_beats in output order.
    // ------------------------------------------------------------------

    task automatic clear_decoder();
        dec_length    = '0;
        dec_phase     = PH_FLAG;
        dec_flags     = '0;
        dec_bits_left = '0;
        dec_pair_high = '0;
        dec_remaining = '0;
        dec_wr_ptr    = 0;
        for (int i = 0; i < WINDOW_BYTES; i++)
            dec_window[i] = 8'h00;
    endtask

    // A write of the length register starts a new stream. The window and
    // its write pointer carry over from the previous stream.
    task automatic load_output_length(input logic [31:0] value);
        dec_length    = value;
        dec_remaining = value;
        dec_phase     = PH_FLAG;
        dec_bits_left = '0;
    endtask

    task automatic push_decoded(input logic [7:0] value);
        out_beat_t beat;
        dec_window[dec_wr_ptr] = value;
        dec_wr_ptr             = (dec_wr_ptr + 1) % WINDOW_BYTES;
        dec_remaining          = dec_remaining - 32'd1;
        beat.data              = value;
        beat.last              = (dec_remaining == 32'd0);
        expected_beats.push_back(beat);
    endtask

    // One flag bit has been used up; a fresh flag byte follows the eighth.
    task automatic retire_flag_bit();
        dec_flags = {dec_flags[6:0], 1'b0};
        if (dec_bits_left != 4'd0)
            dec_bits_left = dec_bits_left - 4'd1;
        dec_phase = (dec_bits_left == 4'd0) ? PH_FLAG : PH_ITEM;
    endtask

    task automatic decode_comp_byte(input logic [7:0] value);
        logic [15:0] pair_word;
        int          distance;
        int          copy_len;
        int          src;
        // A finished stream swallows its input without a trace.
        if (dec_remaining == 0)
            return;
        unique case (dec_phase)
            PH_FLAG:
            begin
                dec_flags     = value;
                dec_bits_left = FLAG_COUNT;
                dec_phase     = PH_ITEM;
            end
            PH_ITEM:
            begin
                if (!dec_flags[7])
                begin
                    push_decoded(value);
                    retire_flag_bit();
                end
                else
                begin
                    dec_pair_high = value;
                    dec_phase     = PH_LOW;
                end
            end
            default:
            begin
                pair_word = {dec_pair_high, value};
                distance  = int'(pair_word[11:0]) + int'(MIN_MATCH);
                copy_len  = int'(pair_word[15:12]) + int'(MIN_MATCH);
                if (copy_len > dec_remaining)
                    copy_len = int'(dec_remaining);
                // Byte-at-a-time copy, so a short distance repeats a run.
                for (int i = 0; i < copy_len; i++)
                begin
                    src = (dec_wr_ptr + WINDOW_BYTES - distance) % WINDOW_BYTES;
                    push_decoded(dec_window[src]);
                end
                retire_flag_bit();
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Shared helpers for the test tasks.
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Mostly back-to-back, sometimes a short gap, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one compressed byte and holds it until the transaction is
    // taken. With no gap the valid stays high into the next call, so it is
    // never dropped and raised within the same time step.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        in_valid  <= 1'b1;
        comp_byte <= value;
        do
            @(posedge clk);
        while (!in_ready);
        decode_comp_byte(value);
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering input, waits for every predicted byte, then lets the
    // block run out any copy that produced nothing we could wait on.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write: setup phase, then access phase until pready, then an idle
    // phase on the bus. Only called while the block is idle, so the decoder
    // takes the value at once.
    task automatic apb_write(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        // Addresses outside the register map leave the block untouched.
        if (addr == ADDR_OUTPUT_LENGTH)
            load_output_length(data);
    endtask

    task automatic apb_read_check();
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_OUTPUT_LENGTH;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== dec_length)
            report_mismatch($sformatf("output_length reads 0x%08h, want 0x%08h",
                                      got, dec_length));
    endtask

    // Picks the next byte of a well-formed stream from the decoder's view
    // of where the parse stands. Pair high bytes favor short distances, so
    // copies land on recent output and overlapping runs are common.
    function automatic logic [7:0] pick_stream_byte();
        logic [3:0] dist_hi;
        if (dec_phase == PH_ITEM && dec_flags[7])
        begin
            dist_hi = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h0;
            return {4'($urandom), dist_hi};
        end
        return 8'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Output side: a random ready pattern, a long hold-off on request, and
    // a fully open mode for stretches with no stalls at all.
    // ------------------------------------------------------------------
    initial
    begin : ready_proc
        int gap;
        int hold;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                hold    = rx_hold;
                rx_hold = 0;
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (rx_steady || $urandom_range(0, 3) != 0)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                out_ready <= 1'b1;
            end
        end
    end

    // Each output transaction is checked against the oldest predicted byte.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                report_mismatch($sformatf("unexpected output byte 0x%02h last %0b",
                                          out_byte, out_last));
            end
            else
            begin
                want_beat = expected_beats.pop_front();
                if (out_byte !== want_beat.data)
                    report_mismatch($sformatf("out_byte 0x%02h, want 0x%02h",
                                              out_byte, want_beat.data));
                if (out_last !== want_beat.last)
                    report_mismatch($sformatf("out_last %0b, want %0b (byte 0x%02h)",
                                              out_last, want_beat.last, want_beat.data));
            end
        end
    end

    // Watchdog: any transaction on any port counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (psel && penable && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("backward_lz_decompressor_top_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test tasks.
    // ------------------------------------------------------------------

    // Out of reset the length is zero, so input is consumed and dropped.
    task automatic test_reset_stream_empty();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h12);
        wait_idle();
        apb_read_check();
    endtask

    // Literals at the byte extremes, then pairs: one reaching far behind
    // the start of the stream (window still zero), the shortest pair, and
    // a long overlapping run that the remaining count cuts short.
    task automatic test_literals_and_pairs();
        logic [7:0] literals [8] = '{8'h00, 8'hFF, 8'hAA, 8'h55,
                                     8'h01, 8'h80, 8'h7F, 8'hFE};
        apb_write(ADDR_OUTPUT_LENGTH, 32'd40);
        apb_read_check();
        send_byte(8'h00);
        foreach (literals[i])
            send_byte(literals[i]);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hF0);
        send_byte(8'h00);
        // The stream is over; these are ignored.
        send_byte(8'h3C);
        send_byte(8'hC3);
        wait_idle();
    endtask

    // Length register at its extremes, a restart with a pair half done,
    // a single-byte stream clamping a pair, and a write outside the map.
    task automatic test_length_extremes();
        apb_write(ADDR_OUTPUT_LENGTH, 32'hFFFF_FFFF);
        apb_read_check();
        send_byte(8'hFF);
        send_byte(8'h3F);
        wait_idle();
        // Restart while the parse waits for a pair low byte.
        apb_write(ADDR_OUTPUT_LENGTH, 32'd1);
        send_byte(8'h80);
        send_byte(8'h50);
        send_byte(8'h02);
        send_byte(8'h99);
        wait_idle();
        apb_write(ADDR_UNMAPPED, 32'h0000_0010);
        apb_read_check();
        send_byte(8'h44);
        wait_idle();
        apb_write(ADDR_OUTPUT_LENGTH, 32'hFFFF_FFFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h81);
        wait_idle();
        apb_write(ADDR_OUTPUT_LENGTH, 32'd0);
        apb_read_check();
        send_byte(8'h5A);
        wait_idle();
    endtask

    // Random streams: mostly well formed and run to their end, some cut
    // off part way and restarted, some trailed by ignored bytes.
    task automatic test_random_streams();
        int          sent;
        int          count;
        int          stop_at;
        int          r;
        logic [31:0] len;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                len = 32'd0;
            else if (r < 3)
                len = $urandom_range(100, 200);
            else
                len = $urandom_range(1, 40);
            apb_write(ADDR_OUTPUT_LENGTH, len);
            stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : -1;
            count   = 0;
            while (dec_remaining != 0 && count != stop_at)
            begin
                send_byte(pick_stream_byte());
                count++;
                sent++;
            end
            if (dec_remaining == 0)
                repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
            wait_idle();
        end
    endtask

    // The receiver stops for a long stretch while long pairs keep coming,
    // so the block backs up and refuses input. The sender then waits for
    // every byte before a stretch with no stalls on either side.
    task automatic test_backpressure();
        apb_write(ADDR_OUTPUT_LENGTH, 32'd300);
        rx_hold = HOLD_CYCLES;
        send_byte(8'hFF);
        repeat (8)
        begin
            send_byte(8'hF0 | 8'($urandom_range(0, 1)));
            send_byte(8'($urandom_range(0, 15)));
        end
        wait_idle();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        apb_write(ADDR_OUTPUT_LENGTH, 32'd30);
        while (dec_remaining != 0)
            send_byte(pick_stream_byte());
        wait_idle();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        clear_decoder();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        comp_byte <= 8'h00;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_stream_empty();
        test_literals_and_pairs();
        test_length_extremes();
        test_random_streams();
        test_backpressure();

        wait_idle();
        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("backward_lz_decompressor_top_tb: PASS");
        else
            $display("backward_lz_decompressor_top_tb: FAIL");
        $finish;
    end

endmodule
